/* rtl/assert_macros.svh */
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion forms for the slot allocator modules. Each use
// expects a clock named clk and a synchronous active-high reset named rst.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication.
`define DSA_ASSERT_IMP(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("%m: same-cycle check failed");

// Next-cycle implication.
`define DSA_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("%m: next-cycle check failed");

`endif

/* rtl/dsa_pkg.sv */
// ----------------------------------------------------------------------------
// Descriptor slot allocator package
// Widths, codes, the bitmap token and the controller states.
// ----------------------------------------------------------------------------
package dsa_pkg;

  localparam int MAX_SLOTS  = 1024;
  localparam int SLOT_W     = $clog2(MAX_SLOTS);
  localparam int CNT_W      = SLOT_W + 1;
  localparam int NCELL      = 4;
  localparam int CELL_W     = $clog2(NCELL);
  localparam int BANK_DEPTH = MAX_SLOTS / NCELL;
  localparam int BANK_W     = SLOT_W - CELL_W;

  localparam int OP_W      = 2;
  localparam int IDX_W     = 16;
  localparam int STAT_W    = 2;
  localparam int CAP_W     = 11;
  localparam int STRIDE_W  = 13;
  localparam int ADDR_W    = 64;
  localparam int CFG_IDX_W = 2;
  localparam int PROD_W    = IDX_W + STRIDE_W;

  localparam logic [SLOT_W-1:0]   LAST_SLOT    = SLOT_W'(MAX_SLOTS - 1);
  localparam logic [CAP_W-1:0]    CAP_RESET    = CAP_W'(1024);
  localparam logic [STRIDE_W-1:0] STRIDE_RESET = STRIDE_W'(32);

  typedef enum logic [OP_W-1:0] {
    OP_ALLOC = 2'd0,
    OP_FREE  = 2'd1,
    OP_XLATE = 2'd2,
    OP_RSVD  = 2'd3
  } op_t;

  typedef enum logic [STAT_W-1:0] {
    STAT_OK    = 2'd0,
    STAT_FULL  = 2'd1,
    STAT_RANGE = 2'd2,
    STAT_DFREE = 2'd3
  } status_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_CAPACITY = 2'd0,
    REG_STRIDE   = 2'd1,
    REG_CPU_BASE = 2'd2,
    REG_GPU_BASE = 2'd3
  } cfg_reg_t;

  typedef enum logic {
    TOK_CLEAR    = 1'b0,
    TOK_TEST_SET = 1'b1
  } tok_kind_t;

  // Token that walks the row of bitmap cells.
  typedef struct packed {
    logic              valid;
    tok_kind_t         kind;
    logic [SLOT_W-1:0] idx;
    logic              hit;
  } tok_t;

  typedef enum logic [2:0] {
    ST_CLEAR = 3'd0,
    ST_DRAIN = 3'd1,
    ST_IDLE  = 3'd2,
    ST_POP   = 3'd3,
    ST_WAIT  = 3'd4,
    ST_DONE  = 3'd5
  } state_t;

endpackage

/* rtl/dsa_cell.sv */
// ----------------------------------------------------------------------------
// Bitmap cell
// Holds one bank of the on-stack bitmap and passes the token to its neighbor.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module dsa_cell
  import dsa_pkg::*;
(
  input  logic              clk,
  input  logic              rst,
  input  logic [CELL_W-1:0] cell_id,
  input  tok_t              tok_in,
  output tok_t              tok_out
);

  logic          bank [BANK_DEPTH];
  tok_t          out_tok;
  logic          rd;
  logic          mine;
  logic [BANK_W-1:0] wr_addr;

  assign mine    = out_tok.valid && (out_tok.idx[SLOT_W-1:BANK_W] == cell_id);
  assign wr_addr = out_tok.idx[BANK_W-1:0];

  always_ff @(posedge clk) begin
    if (rst) begin
      out_tok.valid <= 1'b0;
    end else begin
      out_tok <= tok_in;
    end
  end

  // The bit is read as the token enters and updated while it sits here.
  always_ff @(posedge clk) begin
    rd <= bank[tok_in.idx[BANK_W-1:0]];
    if (mine) begin
      case (out_tok.kind)
        TOK_CLEAR:    bank[wr_addr] <= 1'b0;
        TOK_TEST_SET: if (!rd) bank[wr_addr] <= 1'b1;
        default:      ;
      endcase
    end
  end

  always_comb begin
    tok_out     = out_tok;
    tok_out.hit = out_tok.hit | (mine & rd);
  end

  `DSA_ASSERT_NEXT(a_token_moves, tok_in.valid, tok_out.valid)
  `DSA_ASSERT_NEXT(a_hit_sticks, tok_in.valid && tok_in.hit, tok_out.hit)

endmodule

/* rtl/dsa_addr_gen.sv */
// ----------------------------------------------------------------------------
// Address generator
// Two-stage base plus index times stride for the CPU and GPU spaces.
// ----------------------------------------------------------------------------
module dsa_addr_gen
  import dsa_pkg::*;
(
  input  logic                clk,
  input  logic                rst,
  input  logic                start,
  input  logic [IDX_W-1:0]    idx,
  input  logic [STRIDE_W-1:0] stride,
  input  logic [ADDR_W-1:0]   cpu_base,
  input  logic [ADDR_W-1:0]   gpu_base,
  output logic                done,
  output logic [ADDR_W-1:0]   cpu_addr,
  output logic [ADDR_W-1:0]   gpu_addr
);

  logic [PROD_W-1:0] prod;
  logic              prod_valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      prod_valid <= 1'b0;
      done       <= 1'b0;
    end else begin
      prod_valid <= start;
      done       <= prod_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      prod <= PROD_W'(idx) * PROD_W'(stride);
    end
    if (prod_valid) begin
      cpu_addr <= cpu_base + ADDR_W'(prod);
      gpu_addr <= gpu_base + ADDR_W'(prod);
    end
  end

endmodule

/* rtl/descriptor_slot_allocator_unit.sv */
// ----------------------------------------------------------------------------
// Descriptor slot allocator
// Hands out indices into a table of 1024 equal-size descriptor slots. An
// allocate pops the most recently freed index from a LIFO free stack, or
// else takes the next never-used index, or reports the table full. A free
// rejects an index at or above the capacity and an index already on the
// stack, otherwise pushes it. A translate returns base plus index times
// stride for the CPU and GPU spaces. After reset the block clears its
// on-stack bitmap with req_stall high; configuration writes are taken
// during that time. Requests are handled one at a time. A free and an
// allocate from the stack walk a token through the four bitmap cells,
// each cell owning 256 slots; an allocate from the stack first reads the
// stack memory for the popped index.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module descriptor_slot_allocator_unit
  import dsa_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst,
  // Request channel.
  input  logic                 req_valid,
  output logic                 req_stall,
  input  logic [OP_W-1:0]      op,
  input  logic [IDX_W-1:0]     slot_index,
  // Response channel.
  output logic                 rsp_valid,
  input  logic                 rsp_stall,
  output logic [STAT_W-1:0]    status,
  output logic [SLOT_W-1:0]    granted_index,
  output logic [ADDR_W-1:0]    cpu_address,
  output logic [ADDR_W-1:0]    gpu_address,
  // Configuration write channel.
  input  logic                 cfg_valid,
  output logic                 cfg_ready,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [ADDR_W-1:0]    cfg_data
);

  // Configuration registers.
  logic [CAP_W-1:0]    capacity;
  logic [STRIDE_W-1:0] slot_stride;
  logic [ADDR_W-1:0]   cpu_base_address;
  logic [ADDR_W-1:0]   gpu_base_address;

  // Controller state.
  state_t            state, state_next;
  logic [SLOT_W-1:0] clr_ptr, clr_ptr_next;
  logic [CNT_W-1:0]  free_count, free_count_next;
  logic [CNT_W-1:0]  next_fresh_index, next_fresh_index_next;
  op_t               op_q;
  logic [IDX_W-1:0]  idx_q;
  logic [SLOT_W-1:0] granted_q, granted_next;
  status_t           status_q, status_next;
  logic              use_addr, use_addr_next;
  logic              chain_pend, chain_pend_next;
  logic              addr_pend, addr_pend_next;
  logic              hit_q, hit_next;

  // Free stack memory; only entries below free_count are ever read.
  logic [SLOT_W-1:0] free_stack [MAX_SLOTS];
  logic              stk_rd_en;
  logic [SLOT_W-1:0] stk_rd_addr;
  logic [SLOT_W-1:0] stk_rd;
  logic              stk_wr_en;
  logic [SLOT_W-1:0] stk_wr_addr;
  logic [CNT_W-1:0]  fc_dec;

  // Bitmap chain and address unit.
  tok_t              chain_tok [NCELL+1];
  tok_t              inj;
  tok_t              tail;
  logic              ag_start;
  logic [IDX_W-1:0]  ag_idx;
  logic              ag_done;
  logic [ADDR_W-1:0] ag_cpu;
  logic [ADDR_W-1:0] ag_gpu;

  logic              req_acc;
  logic              load_rsp;
  logic [CNT_W-1:0]  eff_cap;
  logic [STAT_W-1:0] status_r;

  assign cfg_ready = 1'b1;
  assign req_acc   = req_valid && !req_stall;
  assign req_stall = (state != ST_IDLE);

  // A capacity above the table size saturates at the table size.
  assign eff_cap = (capacity > CNT_W'(MAX_SLOTS)) ? CNT_W'(MAX_SLOTS) : capacity;

  assign fc_dec      = free_count - 1'b1;
  assign stk_rd_addr = fc_dec[SLOT_W-1:0];
  assign stk_wr_addr = free_count[SLOT_W-1:0];

  always_ff @(posedge clk) begin
    if (rst) begin
      capacity         <= CAP_RESET;
      slot_stride      <= STRIDE_RESET;
      cpu_base_address <= '0;
      gpu_base_address <= '0;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_reg_t'(cfg_index))
        REG_CAPACITY: capacity         <= cfg_data[CAP_W-1:0];
        REG_STRIDE:   slot_stride      <= cfg_data[STRIDE_W-1:0];
        REG_CPU_BASE: cpu_base_address <= cfg_data;
        REG_GPU_BASE: gpu_base_address <= cfg_data;
        default:      ;
      endcase
    end
  end

  // The token enters the first cell directly from the controller and comes
  // out of the last cell carrying the on-stack bit of its slot.
  assign chain_tok[0] = inj;
  assign tail         = chain_tok[NCELL];

  for (genvar g = 0; g < NCELL; g++) begin : g_cell
    dsa_cell u_cell (
      .clk     (clk),
      .rst     (rst),
      .cell_id (CELL_W'(g)),
      .tok_in  (chain_tok[g]),
      .tok_out (chain_tok[g+1])
    );
  end

  dsa_addr_gen u_addr_gen (
    .clk      (clk),
    .rst      (rst),
    .start    (ag_start),
    .idx      (ag_idx),
    .stride   (slot_stride),
    .cpu_base (cpu_base_address),
    .gpu_base (gpu_base_address),
    .done     (ag_done),
    .cpu_addr (ag_cpu),
    .gpu_addr (ag_gpu)
  );

  always_ff @(posedge clk) begin
    if (stk_rd_en) begin
      stk_rd <= free_stack[stk_rd_addr];
    end
    if (stk_wr_en) begin
      free_stack[stk_wr_addr] <= idx_q[SLOT_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state            <= ST_CLEAR;
      clr_ptr          <= '0;
      free_count       <= '0;
      next_fresh_index <= '0;
      chain_pend       <= 1'b0;
      addr_pend        <= 1'b0;
    end else begin
      state            <= state_next;
      clr_ptr          <= clr_ptr_next;
      free_count       <= free_count_next;
      next_fresh_index <= next_fresh_index_next;
      chain_pend       <= chain_pend_next;
      addr_pend        <= addr_pend_next;
    end
  end

  always_ff @(posedge clk) begin
    if (req_acc) begin
      op_q  <= op_t'(op);
      idx_q <= slot_index;
    end
    granted_q <= granted_next;
    status_q  <= status_next;
    use_addr  <= use_addr_next;
    hit_q     <= hit_next;
  end

  always_comb begin
    state_next            = state;
    clr_ptr_next          = clr_ptr;
    free_count_next       = free_count;
    next_fresh_index_next = next_fresh_index;
    granted_next          = granted_q;
    status_next           = status_q;
    use_addr_next         = use_addr;
    chain_pend_next       = chain_pend;
    addr_pend_next        = addr_pend;
    hit_next              = hit_q;
    inj                   = '0;
    ag_start              = 1'b0;
    ag_idx                = '0;
    stk_rd_en             = 1'b0;
    stk_wr_en             = 1'b0;
    load_rsp              = 1'b0;

    // Completion of the bitmap walk and of the address unit.
    if (tail.valid) begin
      hit_next        = tail.hit;
      chain_pend_next = 1'b0;
    end
    if (ag_done) begin
      addr_pend_next = 1'b0;
    end

    case (state)
      // One clear token per cycle sweeps every slot of the bitmap.
      ST_CLEAR: begin
        inj.valid    = 1'b1;
        inj.kind     = TOK_CLEAR;
        inj.idx      = clr_ptr;
        clr_ptr_next = clr_ptr + 1'b1;
        if (clr_ptr == LAST_SLOT) begin
          state_next = ST_DRAIN;
        end
      end

      ST_DRAIN: begin
        if (tail.valid && tail.kind == TOK_CLEAR && tail.idx == LAST_SLOT) begin
          state_next = ST_IDLE;
        end
      end

      ST_IDLE: begin
        if (req_acc) begin
          hit_next      = 1'b0;
          granted_next  = '0;
          use_addr_next = 1'b0;
          status_next   = STAT_OK;
          case (op_t'(op))
            OP_ALLOC: begin
              if (free_count != '0) begin
                stk_rd_en       = 1'b1;
                free_count_next = fc_dec;
                state_next      = ST_POP;
              end else if (next_fresh_index >= eff_cap) begin
                status_next = STAT_FULL;
                state_next  = ST_DONE;
              end else begin
                granted_next          = next_fresh_index[SLOT_W-1:0];
                next_fresh_index_next = next_fresh_index + 1'b1;
                ag_start              = 1'b1;
                ag_idx                = IDX_W'(next_fresh_index);
                addr_pend_next        = 1'b1;
                use_addr_next         = 1'b1;
                state_next            = ST_WAIT;
              end
            end
            OP_FREE: begin
              if (slot_index >= IDX_W'(eff_cap)) begin
                status_next = STAT_RANGE;
                state_next  = ST_DONE;
              end else begin
                inj.valid       = 1'b1;
                inj.kind        = TOK_TEST_SET;
                inj.idx         = slot_index[SLOT_W-1:0];
                chain_pend_next = 1'b1;
                state_next      = ST_WAIT;
              end
            end
            OP_XLATE: begin
              ag_start       = 1'b1;
              ag_idx         = slot_index;
              addr_pend_next = 1'b1;
              use_addr_next  = 1'b1;
              state_next     = ST_WAIT;
            end
            default: begin
              state_next = ST_DONE;
            end
          endcase
        end
      end

      // The popped index is known now: clear its bit and start its address.
      ST_POP: begin
        granted_next    = stk_rd;
        inj.valid       = 1'b1;
        inj.kind        = TOK_CLEAR;
        inj.idx         = stk_rd;
        chain_pend_next = 1'b1;
        ag_start        = 1'b1;
        ag_idx          = IDX_W'(stk_rd);
        addr_pend_next  = 1'b1;
        use_addr_next   = 1'b1;
        state_next      = ST_WAIT;
      end

      ST_WAIT: begin
        if (!chain_pend && !addr_pend) begin
          if (op_q == OP_FREE) begin
            if (hit_q) begin
              status_next = STAT_DFREE;
            end else if (free_count < CNT_W'(MAX_SLOTS)) begin
              stk_wr_en       = 1'b1;
              free_count_next = free_count + 1'b1;
            end
          end
          state_next = ST_DONE;
        end
      end

      // The response register is loaded once it is empty or being drained.
      ST_DONE: begin
        if (!rsp_valid || !rsp_stall) begin
          load_rsp   = 1'b1;
          state_next = ST_IDLE;
        end
      end

      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  // Output register: parts the response side from the controller.
  always_ff @(posedge clk) begin
    if (rst) begin
      rsp_valid <= 1'b0;
    end else if (load_rsp) begin
      rsp_valid <= 1'b1;
    end else if (!rsp_stall) begin
      rsp_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load_rsp) begin
      status_r      <= status_q;
      granted_index <= granted_q;
      cpu_address   <= use_addr ? ag_cpu : '0;
      gpu_address   <= use_addr ? ag_gpu : '0;
    end
  end

  assign status = status_r;

  `DSA_ASSERT_IMP(a_push_has_room, stk_wr_en, free_count < CNT_W'(MAX_SLOTS))
  `DSA_ASSERT_NEXT(a_pop_reads_stack, req_acc && op == OP_ALLOC && free_count != '0, state == ST_POP)
  `DSA_ASSERT_IMP(a_grant_only_ok, rsp_valid && granted_index != '0, status == STAT_OK)

endmodule
